@@ rtl/core/kclp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key click package
// Shared types and constants of the key click and long-press classifier.
// ----------------------------------------------------------------------------
package kclp_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned THRESH_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        ST_UP     = 3'd0,
        ST_DOWN   = 3'd1,
        ST_HOLD   = 3'd2,
        ST_LHOLD  = 3'd3,
        ST_CLICK  = 3'd4,
        ST_LCLICK = 3'd5
    } t_press_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WATCH_MASK = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_QUERY_HOLD = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 16'd3000;
    localparam logic [THRESH_W-1:0] QUERY_HOLD_RESET = 16'd3000;

endpackage
`default_nettype wire

@@ rtl/core/kclp_key_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key sample channel
// Carries one word of raw key levels and the millisecond time of the sample.
// ----------------------------------------------------------------------------
interface kclp_key_if #(
    parameter int unsigned KEY_BITS = 6
);
    logic                              valid;
    logic                              ready;
    logic [KEY_BITS-1:0]               key_levels;
    logic [kclp_pkg::TIME_W-1:0]       now_ms;

    modport source (output valid, output key_levels, output now_ms, input ready);
    modport sink   (input valid, input key_levels, input now_ms, output ready);
endinterface
`default_nettype wire

@@ rtl/core/kclp_press_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Press result channel
// Carries the press state after each sample and the long-hold flag.
// ----------------------------------------------------------------------------
interface kclp_press_if;
    logic       valid;
    logic       ready;
    logic [2:0] press_state;
    logic       long_hold_flag;

    modport source (output valid, output press_state, output long_hold_flag, input ready);
    modport sink   (input valid, input press_state, input long_hold_flag, output ready);
endinterface
`default_nettype wire

@@ rtl/core/key_click_long_press_fsm_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key click and long-press classifier
// Follows a group of key lines through up, down, hold, long hold, click and
// long click, and reports the new state with a long-hold flag per sample.
// ----------------------------------------------------------------------------
// Usage:
//   i_key carries one word per sample: raw key levels and the millisecond
//   time. o_press returns exactly one word per sample, in order.
//   The configuration port writes watch mask, long-press and query
//   thresholds; the user must write it only while no sample is in flight;
//   the block does not enforce this. A sample is captured in the input
//   register, then the state update and the elapsed-time compare run
//   combinationally into the result register, which offers the result;
//   one sample is accepted per cycle while o_press is taken.
//   When the receiver stalls, the result register holds and the input
//   register takes one further sample; i_key.ready then falls until the
//   result is taken.
//   Synchronous reset returns the state to up, clears the stamp and watch
//   mask, empties both registers and loads threshold defaults of 3000 ms.
// ----------------------------------------------------------------------------
module key_click_long_press_fsm_top #(
    parameter int unsigned KEY_BITS = 6
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    kclp_key_if.sink                                   i_key,
    kclp_press_if.source                               o_press,
    input  wire logic                                  i_cfg_we,
    input  wire logic [kclp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [((KEY_BITS > kclp_pkg::THRESH_W) ?
                        KEY_BITS : kclp_pkg::THRESH_W)-1:0] i_cfg_wdata
);

    localparam int unsigned TW = kclp_pkg::TIME_W;
    localparam int unsigned HW = kclp_pkg::THRESH_W;

    logic [KEY_BITS-1:0]        r_watch_mask;
    logic [HW-1:0]              r_long_press;
    logic [HW-1:0]              r_query_hold;

    logic                       r_in_valid;
    logic [KEY_BITS-1:0]        r_in_levels;
    logic [TW-1:0]              r_in_now;

    kclp_pkg::t_press_state     r_state;
    kclp_pkg::t_press_state     n_state;
    logic [TW-1:0]              r_stamp;
    logic [TW-1:0]              n_stamp;
    logic                       n_flag;

    logic                       r_out_valid;
    kclp_pkg::t_press_state     r_out_state;
    logic                       r_out_flag;

    logic                       advance;
    logic                       pressed;
    logic [TW-1:0]              elapsed;
    logic                       over_long;
    logic                       over_query;

    assign advance     = r_in_valid && (!r_out_valid || o_press.ready);
    assign i_key.ready = !r_in_valid || advance;

    assign pressed    = |(r_in_levels & r_watch_mask);
    assign elapsed    = r_in_now - r_stamp;
    assign over_long  = elapsed > {{(TW-HW){1'b0}}, r_long_press};
    assign over_query = elapsed > {{(TW-HW){1'b0}}, r_query_hold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watch_mask <= '0;
            r_long_press <= kclp_pkg::LONG_PRESS_RESET;
            r_query_hold <= kclp_pkg::QUERY_HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (kclp_pkg::t_cfg_idx'(i_cfg_idx))
                kclp_pkg::CFG_WATCH_MASK: r_watch_mask <= i_cfg_wdata[KEY_BITS-1:0];
                kclp_pkg::CFG_LONG_PRESS: r_long_press <= i_cfg_wdata[HW-1:0];
                kclp_pkg::CFG_QUERY_HOLD: r_query_hold <= i_cfg_wdata[HW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_key.ready) begin
            r_in_valid <= i_key.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key.valid && i_key.ready) begin
            r_in_levels <= i_key.key_levels;
            r_in_now    <= i_key.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kclp_pkg::ST_UP;
            r_stamp <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_stamp <= n_stamp;
        end
    end

    always_comb begin
        n_state = r_state;
        n_stamp = r_stamp;
        n_flag  = 1'b0;
        unique case (r_state)
            kclp_pkg::ST_UP, kclp_pkg::ST_CLICK, kclp_pkg::ST_LCLICK: begin
                n_state = pressed ? kclp_pkg::ST_DOWN : kclp_pkg::ST_UP;
            end
            kclp_pkg::ST_DOWN: begin
                if (pressed) begin
                    n_state = kclp_pkg::ST_HOLD;
                    n_stamp = r_in_now;
                end else begin
                    n_state = kclp_pkg::ST_CLICK;
                end
            end
            kclp_pkg::ST_HOLD: begin
                if (!pressed) begin
                    n_state = kclp_pkg::ST_CLICK;
                end else if (over_long) begin
                    n_state = kclp_pkg::ST_LHOLD;
                    n_flag  = 1'b1;
                end else begin
                    n_flag  = over_query;
                end
            end
            kclp_pkg::ST_LHOLD: begin
                n_state = pressed ? kclp_pkg::ST_LHOLD : kclp_pkg::ST_LCLICK;
                n_flag  = pressed;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_press.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_state <= n_state;
            r_out_flag  <= n_flag;
        end
    end

    assign o_press.valid          = r_out_valid;
    assign o_press.press_state    = r_out_state;
    assign o_press.long_hold_flag = r_out_flag;

    a_lhold_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_state == kclp_pkg::ST_LHOLD |-> r_out_flag)
        else $error("long hold reported without the long-hold flag");

    a_flag_only_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_state != kclp_pkg::ST_HOLD
        && r_out_state != kclp_pkg::ST_LHOLD |-> !r_out_flag)
        else $error("long-hold flag set outside hold");

    a_stamp_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_state == kclp_pkg::ST_DOWN && pressed
        |=> r_stamp == $past(r_in_now) && !r_out_flag)
        else $error("hold entered without stamping the sample time");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed word lost before the result register");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_key.ready)
        else $error("input stalled while the result register is empty");

endmodule
`default_nettype wire

@@ tb/sv/tb_key_click_long_press_fsm_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key click and long-press classifier testbench
// Feeds key samples with random gaps and random result stalls, predicts the
// press state and long-hold flag of every sample and checks each result word
// in order. Threshold and mask settings change between phases.
// ----------------------------------------------------------------------------
module tb_key_click_long_press_fsm_top;

    localparam int unsigned KEY_BITS       = 6;
    localparam int unsigned TIME_W         = kclp_pkg::TIME_W;
    localparam int unsigned THRESH_W       = kclp_pkg::THRESH_W;
    localparam int unsigned CFG_W          = (KEY_BITS > THRESH_W) ? KEY_BITS : THRESH_W;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES    = 10;

    typedef struct packed {
        logic [KEY_BITS-1:0] levels;
        logic [TIME_W-1:0]   now;
    } t_key_word;

    typedef struct packed {
        kclp_pkg::t_press_state state;
        logic                   long_hold;
    } t_press_word;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [kclp_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]               i_cfg_wdata;

    kclp_key_if #(.KEY_BITS(KEY_BITS)) key_if ();
    kclp_press_if                      press_if ();

    key_click_long_press_fsm_top #(
        .KEY_BITS (KEY_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (key_if),
        .o_press     (press_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted classifier state and its copy of the registers.
    kclp_pkg::t_press_state fsm_q;
    logic [TIME_W-1:0]      stamp_q;
    logic [KEY_BITS-1:0]    watch_q;
    logic [THRESH_W-1:0]    long_press_q;
    logic [THRESH_W-1:0]    query_hold_q;

    t_key_word   pending_samples[$];
    t_press_word expected_presses[$];
    int unsigned samples_queued = 0;
    int unsigned samples_taken  = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned src_wait       = 0;
    int unsigned sink_stall     = 0;
    bit          src_burst      = 1'b0;
    bit          sink_burst     = 1'b0;
    logic [TIME_W-1:0] time_cursor = '0;

    function automatic t_press_word classify_sample(input logic [KEY_BITS-1:0] levels,
                                                    input logic [TIME_W-1:0]   now);
        t_press_word       w;
        logic              pressed;
        logic [TIME_W-1:0] held;
        pressed = |(levels & watch_q);
        held    = now - stamp_q;
        case (fsm_q)
            kclp_pkg::ST_UP, kclp_pkg::ST_CLICK, kclp_pkg::ST_LCLICK: begin
                fsm_q = pressed ? kclp_pkg::ST_DOWN : kclp_pkg::ST_UP;
            end
            kclp_pkg::ST_DOWN: begin
                if (pressed) begin
                    fsm_q   = kclp_pkg::ST_HOLD;
                    stamp_q = now;
                end else begin
                    fsm_q = kclp_pkg::ST_CLICK;
                end
            end
            kclp_pkg::ST_HOLD: begin
                if (!pressed) begin
                    fsm_q = kclp_pkg::ST_CLICK;
                end else if (held > {16'd0, long_press_q}) begin
                    fsm_q = kclp_pkg::ST_LHOLD;
                end
            end
            kclp_pkg::ST_LHOLD: begin
                fsm_q = pressed ? kclp_pkg::ST_LHOLD : kclp_pkg::ST_LCLICK;
            end
            default: begin
            end
        endcase
        held        = now - stamp_q;
        w.state     = fsm_q;
        w.long_hold = (fsm_q == kclp_pkg::ST_LHOLD) ||
                      ((fsm_q == kclp_pkg::ST_HOLD) && (held > {16'd0, query_hold_q}));
        return w;
    endfunction

    // Sample driver.
    always @(posedge i_clk) begin : drive_samples
        t_key_word smp;
        if (!i_rst_n) begin
            key_if.valid <= 1'b0;
            src_wait     <= 0;
        end else begin
            if (key_if.valid && key_if.ready) begin
                expected_presses.push_back(classify_sample(key_if.key_levels, key_if.now_ms));
                samples_taken++;
            end
            if (!key_if.valid || key_if.ready) begin
                if (src_wait != 0) begin
                    src_wait     <= src_wait - 1;
                    key_if.valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    smp = pending_samples.pop_front();
                    key_if.valid      <= 1'b1;
                    key_if.key_levels <= smp.levels;
                    key_if.now_ms     <= smp.now;
                    if ($urandom_range(0, 39) == 0) begin
                        src_burst = !src_burst;
                    end
                    src_wait <= src_burst ? 0 : $urandom_range(0, 6);
                end else begin
                    key_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker.
    always @(posedge i_clk) begin : check_presses
        t_press_word exp_w;
        int unsigned nxt;
        if (!i_rst_n) begin
            press_if.ready <= 1'b0;
            sink_stall     <= 0;
        end else begin
            if (press_if.valid && press_if.ready) begin
                if (expected_presses.size() == 0) begin
                    $display("%0t: result word with nothing expected, state %0d flag %0b",
                             $time, press_if.press_state, press_if.long_hold_flag);
                    mismatch_count++;
                end else begin
                    exp_w = expected_presses.pop_front();
                    if (press_if.press_state !== exp_w.state) begin
                        $display("%0t: press_state expected %0d, actual %0d",
                                 $time, exp_w.state, press_if.press_state);
                        mismatch_count++;
                    end
                    if (press_if.long_hold_flag !== exp_w.long_hold) begin
                        $display("%0t: long_hold_flag expected %0b, actual %0b",
                                 $time, exp_w.long_hold, press_if.long_hold_flag);
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    sink_burst = !sink_burst;
                end
                nxt = sink_burst ? 0 : $urandom_range(0, 6);
                sink_stall     <= nxt;
                press_if.ready <= (nxt == 0);
            end else if (sink_stall != 0) begin
                sink_stall     <= sink_stall - 1;
                press_if.ready <= (sink_stall == 1);
            end else begin
                press_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((key_if.valid && key_if.ready) || (press_if.valid && press_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("tb_key_click_long_press_fsm_top: errors");
                $finish;
            end
        end
    end

    task automatic queue_sample(input logic [KEY_BITS-1:0] levels, input logic [TIME_W-1:0] now);
        t_key_word smp;
        smp.levels = levels;
        smp.now    = now;
        pending_samples.push_back(smp);
        samples_queued++;
    endtask

    function automatic logic [KEY_BITS-1:0] pressed_levels();
        logic [KEY_BITS-1:0] pick;
        pick = KEY_BITS'($urandom) & watch_q;
        if (pick == '0) begin
            pick = watch_q;
        end
        return pick | (KEY_BITS'($urandom) & ~watch_q);
    endfunction

    function automatic logic [KEY_BITS-1:0] released_levels();
        return KEY_BITS'($urandom) & ~watch_q;
    endfunction

    task automatic wait_for_drain();
        while (samples_taken != samples_queued || expected_presses.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input kclp_pkg::t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            kclp_pkg::CFG_WATCH_MASK: watch_q      = data[KEY_BITS-1:0];
            kclp_pkg::CFG_LONG_PRESS: long_press_q = data[THRESH_W-1:0];
            kclp_pkg::CFG_QUERY_HOLD: query_hold_q = data[THRESH_W-1:0];
            default: begin
            end
        endcase
    endtask

    // A release, a press into down, usually a run of held samples placed
    // around the thresholds, and a final release.
    task automatic add_press_episode();
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] held;
        if ($urandom_range(0, 15) == 0) begin
            time_cursor = 32'hFFFF_FFFF - $urandom_range(0, 200);
        end else if ($urandom_range(0, 15) == 0) begin
            time_cursor = $urandom;
        end
        queue_sample(released_levels(), time_cursor);
        time_cursor += $urandom_range(1, 40);
        queue_sample(pressed_levels(), time_cursor);
        time_cursor += $urandom_range(1, 40);
        if ($urandom_range(0, 5) == 0) begin
            queue_sample(released_levels(), time_cursor);
        end else begin
            stamp = time_cursor;
            queue_sample(pressed_levels(), stamp);
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 7))
                    0: held = {16'd0, long_press_q};
                    1: held = {16'd0, long_press_q} + 1;
                    2: held = {16'd0, query_hold_q};
                    3: held = {16'd0, query_hold_q} + 1;
                    4: held = $urandom_range(0, 200);
                    5: held = $urandom_range(0, 70000);
                    6: held = {16'd0, long_press_q} - 1;
                    default: held = $urandom;
                endcase
                time_cursor = stamp + held;
                queue_sample(pressed_levels(), time_cursor);
            end
            time_cursor += $urandom_range(1, 40);
            queue_sample(released_levels(), time_cursor);
        end
    endtask

    task automatic run_phase(input logic [KEY_BITS-1:0] watch, input logic [THRESH_W-1:0] long_ms,
                             input logic [THRESH_W-1:0] query_ms, input int unsigned count);
        logic [CFG_W-1:0] wdata;
        int unsigned      target;
        wait_for_drain();
        wdata                 = CFG_W'($urandom);
        wdata[KEY_BITS-1:0]   = watch;
        write_reg(kclp_pkg::CFG_WATCH_MASK, wdata);
        write_reg(kclp_pkg::CFG_LONG_PRESS, CFG_W'(long_ms));
        write_reg(kclp_pkg::CFG_QUERY_HOLD, CFG_W'(query_ms));
        write_reg(kclp_pkg::CFG_UNUSED, CFG_W'($urandom));
        target = samples_queued + count;
        while (samples_queued < target) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        time_cursor = $urandom;
                    end else begin
                        time_cursor += $urandom_range(0, 100);
                    end
                    queue_sample(KEY_BITS'($urandom), time_cursor);
                end
            end else begin
                add_press_episode();
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = kclp_pkg::CFG_WATCH_MASK;
        i_cfg_wdata       = '0;
        key_if.valid      = 1'b0;
        key_if.key_levels = '0;
        key_if.now_ms     = '0;
        press_if.ready    = 1'b0;
        fsm_q             = kclp_pkg::ST_UP;
        stamp_q           = '0;
        watch_q           = '0;
        long_press_q      = kclp_pkg::LONG_PRESS_RESET;
        query_hold_q      = kclp_pkg::QUERY_HOLD_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // After reset the mask is empty, so no key line counts as pressed.
        queue_sample(6'h3F, 32'h0000_0000);
        queue_sample(6'h3F, 32'hFFFF_FFFF);
        queue_sample(6'h00, 32'h0000_0010);
        queue_sample(6'h2A, 32'h0000_0020);
        wait_for_drain();

        write_reg(kclp_pkg::CFG_UNUSED, 16'hFFFF);
        write_reg(kclp_pkg::CFG_WATCH_MASK, 16'hFFFF);
        write_reg(kclp_pkg::CFG_LONG_PRESS, 16'd100);
        write_reg(kclp_pkg::CFG_QUERY_HOLD, 16'd50);

        // Click from down, both thresholds hit exactly and just passed,
        // long click, and a hold that spans the wrap of the time.
        queue_sample(6'h00, 32'd0);
        queue_sample(6'h3F, 32'd0);
        queue_sample(6'h00, 32'd5);
        queue_sample(6'h00, 32'd6);
        queue_sample(6'h01, 32'd10);
        queue_sample(6'h20, 32'd20);
        queue_sample(6'h15, 32'd70);
        queue_sample(6'h2A, 32'd71);
        queue_sample(6'h3F, 32'd120);
        queue_sample(6'h3F, 32'd121);
        queue_sample(6'h3F, 32'd5000);
        queue_sample(6'h00, 32'd5001);
        queue_sample(6'h08, 32'd5002);
        queue_sample(6'h00, 32'd5003);
        queue_sample(6'h00, 32'hFFFF_FFF0);
        queue_sample(6'h3F, 32'hFFFF_FFF0);
        queue_sample(6'h3F, 32'hFFFF_FFFF);
        queue_sample(6'h02, 32'h0000_0032);
        queue_sample(6'h04, 32'h0000_0064);
        queue_sample(6'h00, 32'h0000_0065);

        run_phase(6'h3F, 16'd3000, 16'd3000, 225);
        run_phase(6'h01, 16'd0, 16'd0, 225);
        run_phase(6'h20, 16'hFFFF, 16'hFFFF, 225);
        run_phase(6'h0C, 16'd500, 16'd2000, 225);
        run_phase(6'h12, 16'd2000, 16'd10, 225);
        run_phase(6'h00, 16'd100, 16'd100, 50);
        run_phase(KEY_BITS'($urandom), THRESH_W'($urandom_range(0, 5000)),
                  THRESH_W'($urandom_range(0, 5000)), 225);
        run_phase(KEY_BITS'($urandom) | 6'h01, THRESH_W'($urandom),
                  THRESH_W'($urandom), 225);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_presses.size() == 0) begin
            $display("tb_key_click_long_press_fsm_top: clean");
        end else begin
            $display("tb_key_click_long_press_fsm_top: errors");
        end
        $finish;
    end

endmodule
